// ----- rtl/cpu8alu_pkg.sv -----
// Shared types, operation codes and reset values for the 8-bit register/ALU unit.
package cpu8alu_pkg;

    localparam int BYTE_W   = 8;
    localparam int CMD_W    = 6;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 48;

    // Reset values of the programmer-visible registers
    localparam logic [BYTE_W-1:0] RESET_ACC = 8'h00;
    localparam logic [BYTE_W-1:0] RESET_X   = 8'h00;
    localparam logic [BYTE_W-1:0] RESET_Y   = 8'h00;
    localparam logic [BYTE_W-1:0] RESET_SP  = 8'hFF;

    // Status byte bit positions: N V 1 B D I Z C
    localparam int ST_C   = 0;
    localparam int ST_Z   = 1;
    localparam int ST_I   = 2;
    localparam int ST_D   = 3;
    localparam int ST_B   = 4;
    localparam int ST_ONE = 5;
    localparam int ST_V   = 6;
    localparam int ST_N   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_LDA  = 6'd0,  CMD_LDX  = 6'd1,  CMD_LDY  = 6'd2,  CMD_AND  = 6'd3,
        CMD_ORA  = 6'd4,  CMD_EOR  = 6'd5,  CMD_ADC  = 6'd6,  CMD_SBC  = 6'd7,
        CMD_CMP  = 6'd8,  CMD_CPX  = 6'd9,  CMD_CPY  = 6'd10, CMD_BIT  = 6'd11,
        CMD_ASLA = 6'd12, CMD_LSRA = 6'd13, CMD_ROLA = 6'd14, CMD_RORA = 6'd15,
        CMD_ASLM = 6'd16, CMD_LSRM = 6'd17, CMD_ROLM = 6'd18, CMD_RORM = 6'd19,
        CMD_INCM = 6'd20, CMD_DECM = 6'd21, CMD_INX  = 6'd22, CMD_INY  = 6'd23,
        CMD_DEX  = 6'd24, CMD_DEY  = 6'd25, CMD_TAX  = 6'd26, CMD_TAY  = 6'd27,
        CMD_TXA  = 6'd28, CMD_TYA  = 6'd29, CMD_TSX  = 6'd30, CMD_TXS  = 6'd31,
        CMD_CLC  = 6'd32, CMD_SEC  = 6'd33, CMD_SEI  = 6'd34, CMD_CLD  = 6'd35,
        CMD_SED  = 6'd36, CMD_CLV  = 6'd37, CMD_PHP  = 6'd38, CMD_PLP  = 6'd39,
        CMD_STA  = 6'd40, CMD_STX  = 6'd41, CMD_STY  = 6'd42
    } cmd_t;

    // Architectural state: registers and flags
    typedef struct packed {
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] sp;
        logic              c;
        logic              z;
        logic              i;
        logic              d;
        logic              v;
        logic              n;
    } cpu_state_t;

    localparam cpu_state_t RESET_STATE = '{
        acc: RESET_ACC, x: RESET_X, y: RESET_Y, sp: RESET_SP,
        c: 1'b0, z: 1'b0, i: 1'b1, d: 1'b0, v: 1'b0, n: 1'b0
    };

    // Pack flags into the status byte, bit 5 always set, break bit clear
    function automatic logic [BYTE_W-1:0] pack_status(input cpu_state_t st);
        logic [BYTE_W-1:0] p;
        p         = '0;
        p[ST_N]   = st.n;
        p[ST_V]   = st.v;
        p[ST_ONE] = 1'b1;
        p[ST_D]   = st.d;
        p[ST_I]   = st.i;
        p[ST_Z]   = st.z;
        p[ST_C]   = st.c;
        return p;
    endfunction

endpackage

// ----- rtl/cpu8alu_exec.sv -----
// Combinational execute step: one operation on the current state and operand.
module cpu8alu_exec import cpu8alu_pkg::*; (
    input  cpu_state_t        st,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [BYTE_W-1:0] operand,
    output cpu_state_t        st_next,
    output logic [BYTE_W-1:0] result_byte
);

    cmd_t              op;
    logic [BYTE_W-1:0] add_m;
    logic [BYTE_W:0]   add_sum;
    logic [BYTE_W-1:0] cmp_reg;
    logic [BYTE_W:0]   cmp_diff;
    logic [BYTE_W-1:0] sh_src;
    logic [BYTE_W:0]   sh_out;
    logic [BYTE_W-1:0] nz_val;
    logic              nz_en;

    assign op = cmd_t'(cmd);

    // Adder: SBC adds the inverted operand
    assign add_m   = (op == CMD_SBC) ? ~operand : operand;
    assign add_sum = {1'b0, st.acc} + {1'b0, add_m} + {{BYTE_W{1'b0}}, st.c};

    // Comparator subtract against the selected register
    always_comb begin
        unique case (op)
            CMD_CPX: cmp_reg = st.x;
            CMD_CPY: cmp_reg = st.y;
            default: cmp_reg = st.acc;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

    // Shifter: {carry out, result}; kind is the low two bits of the code
    assign sh_src = cmd[4] ? operand : st.acc;
    always_comb begin
        unique case (cmd[1:0])
            2'd0:    sh_out = {sh_src[BYTE_W-1], sh_src[BYTE_W-2:0], 1'b0};
            2'd1:    sh_out = {sh_src[0], 1'b0, sh_src[BYTE_W-1:1]};
            2'd2:    sh_out = {sh_src[BYTE_W-1], sh_src[BYTE_W-2:0], st.c};
            default: sh_out = {sh_src[0], st.c, sh_src[BYTE_W-1:1]};
        endcase
    end

    // Operation decode
    always_comb begin
        st_next     = st;
        result_byte = '0;
        nz_val      = '0;
        nz_en       = 1'b0;
        unique case (op)
            CMD_LDA: begin st_next.acc = operand; nz_val = operand; nz_en = 1'b1; end
            CMD_LDX: begin st_next.x = operand; nz_val = operand; nz_en = 1'b1; end
            CMD_LDY: begin st_next.y = operand; nz_val = operand; nz_en = 1'b1; end
            CMD_AND: begin
                st_next.acc = st.acc & operand; nz_val = st.acc & operand; nz_en = 1'b1;
            end
            CMD_ORA: begin
                st_next.acc = st.acc | operand; nz_val = st.acc | operand; nz_en = 1'b1;
            end
            CMD_EOR: begin
                st_next.acc = st.acc ^ operand; nz_val = st.acc ^ operand; nz_en = 1'b1;
            end
            CMD_ADC, CMD_SBC: begin
                st_next.acc = add_sum[BYTE_W-1:0];
                st_next.c   = add_sum[BYTE_W];
                st_next.v   = (st.acc[BYTE_W-1] ^ add_sum[BYTE_W-1])
                            & (add_m[BYTE_W-1] ^ add_sum[BYTE_W-1]);
                nz_val      = add_sum[BYTE_W-1:0];
                nz_en       = 1'b1;
            end
            CMD_CMP, CMD_CPX, CMD_CPY: begin
                st_next.c = ~cmp_diff[BYTE_W];
                st_next.z = (cmp_reg == operand);
                st_next.n = cmp_diff[BYTE_W-1];
            end
            CMD_BIT: begin
                st_next.z = ((st.acc & operand) == '0);
                st_next.n = operand[ST_N];
                st_next.v = operand[ST_V];
            end
            CMD_ASLA, CMD_LSRA, CMD_ROLA, CMD_RORA: begin
                st_next.acc = sh_out[BYTE_W-1:0];
                st_next.c   = sh_out[BYTE_W];
                nz_val      = sh_out[BYTE_W-1:0];
                nz_en       = 1'b1;
            end
            CMD_ASLM, CMD_LSRM, CMD_ROLM, CMD_RORM: begin
                result_byte = sh_out[BYTE_W-1:0];
                st_next.c   = sh_out[BYTE_W];
                nz_val      = sh_out[BYTE_W-1:0];
                nz_en       = 1'b1;
            end
            CMD_INCM: begin
                result_byte = operand + 8'd1; nz_val = operand + 8'd1; nz_en = 1'b1;
            end
            CMD_DECM: begin
                result_byte = operand - 8'd1; nz_val = operand - 8'd1; nz_en = 1'b1;
            end
            CMD_INX: begin st_next.x = st.x + 8'd1; nz_val = st.x + 8'd1; nz_en = 1'b1; end
            CMD_INY: begin st_next.y = st.y + 8'd1; nz_val = st.y + 8'd1; nz_en = 1'b1; end
            CMD_DEX: begin st_next.x = st.x - 8'd1; nz_val = st.x - 8'd1; nz_en = 1'b1; end
            CMD_DEY: begin st_next.y = st.y - 8'd1; nz_val = st.y - 8'd1; nz_en = 1'b1; end
            CMD_TAX: begin st_next.x = st.acc; nz_val = st.acc; nz_en = 1'b1; end
            CMD_TAY: begin st_next.y = st.acc; nz_val = st.acc; nz_en = 1'b1; end
            CMD_TXA: begin st_next.acc = st.x; nz_val = st.x; nz_en = 1'b1; end
            CMD_TYA: begin st_next.acc = st.y; nz_val = st.y; nz_en = 1'b1; end
            CMD_TSX: begin st_next.x = st.sp; nz_val = st.sp; nz_en = 1'b1; end
            CMD_TXS: st_next.sp = st.x;
            CMD_CLC: st_next.c = 1'b0;
            CMD_SEC: st_next.c = 1'b1;
            CMD_SEI: st_next.i = 1'b1;
            CMD_CLD: st_next.d = 1'b0;
            CMD_SED: st_next.d = 1'b1;
            CMD_CLV: st_next.v = 1'b0;
            CMD_PHP: begin
                result_byte        = pack_status(st);
                result_byte[ST_B]  = 1'b1;
                st_next.sp         = st.sp - 8'd1;
            end
            CMD_PLP: begin
                st_next.c  = operand[ST_C];
                st_next.z  = operand[ST_Z];
                st_next.i  = operand[ST_I];
                st_next.d  = operand[ST_D];
                st_next.v  = operand[ST_V];
                st_next.n  = operand[ST_N];
                st_next.sp = st.sp + 8'd1;
            end
            CMD_STA: result_byte = st.acc;
            CMD_STX: result_byte = st.x;
            CMD_STY: result_byte = st.y;
            default: ;
        endcase
        // Update zero and negative from the produced value
        if (nz_en) begin
            st_next.z = (nz_val == '0);
            st_next.n = nz_val[BYTE_W-1];
        end
    end

endmodule

// ----- rtl/cpu8alu_regs.sv -----
// Architectural register and flag storage with load enable.
module cpu8alu_regs import cpu8alu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  cpu_state_t st_next,
    output cpu_state_t st
);

    cpu_state_t st_reg;

    // Hold state; load the executed value on each issued beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= RESET_STATE;
        end else if (load) begin
            st_reg <= st_next;
        end
    end

    assign st = st_reg;

endmodule

// ----- rtl/cpu8_alu_register_unit.sv -----
// Top level of the 8-bit register/ALU unit: input stage, execute, result stage.
//
//  Channel  | Direction | Payload (tdata, low bit up)
//  ---------+-----------+------------------------------------------------------
//  s_       | in        | cmd[5:0], operand[13:6], zero pad [15:14]
//  m_       | out       | result_byte, status_byte, acc_out, x_out, y_out, sp_out
//
// One beat per cycle sustained while m_tready is high; an s_ beat goes through the
// input register, then execute into the result register, to become the m_ beat.
// The state registers update when an item leaves the input register, so the
// next item in line sees the new values in the following cycle.
// Reset (aresetn low, synchronous) empties both stages and loads register reset values.
// A stall on m_tready holds the result register and any beat waiting in the input stage.
module cpu8_alu_register_unit import cpu8alu_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // cmd[5:0], operand[13:6]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // result_byte[7:0], status_byte[15:8],
                                           // acc_out[23:16], x_out[31:24],
                                           // y_out[39:32], sp_out[47:40]
);

    logic                in_valid_reg;
    logic [CMD_W-1:0]    in_cmd_reg;
    logic [BYTE_W-1:0]   in_operand_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;
    logic                out_free;
    logic                issue;
    cpu_state_t          st;
    cpu_state_t          st_next;
    logic [BYTE_W-1:0]   result_byte;

    // Stage handshake: result slot frees when taken; input slot frees on issue
    assign out_free = !out_valid_reg || m_tready;
    assign issue    = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg     <= s_tdata[CMD_W-1:0];
            in_operand_reg <= s_tdata[CMD_W+BYTE_W-1:CMD_W];
        end
    end

    cpu8alu_exec u_exec (
        .st          (st),
        .cmd         (in_cmd_reg),
        .operand     (in_operand_reg),
        .st_next     (st_next),
        .result_byte (result_byte)
    );

    cpu8alu_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (issue),
        .st_next (st_next),
        .st      (st)
    );

    // Pack the result beat
    assign out_data_next = {st_next.sp, st_next.y, st_next.x, st_next.acc,
                            pack_status(st_next), result_byte};

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_cmd_reg)
            && $stable(in_operand_reg))
        else $error("input stage lost a waiting beat");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !issue |=> $stable(st))
        else $error("state changed without an issued beat");

    a_out_from_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(issue))
        else $error("result beat appeared without an issue");

    a_status_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[BYTE_W+ST_ONE])
        else $error("status bit 5 clear on result beat");

    a_php_sp: assert property (@(posedge aclk) disable iff (!aresetn)
        issue && (in_cmd_reg == CMD_PHP) |=> st.sp == $past(st.sp) - 8'd1)
        else $error("stack pointer not decremented on push");
`endif

endmodule
